// File: sv/lru_kv_pkg.sv
// Shared types and constants for the LRU key/value cache.
package lru_kv_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int CAP_W   = 5;
    localparam int EXT_W   = (CAP_W > CNT_W) ? CAP_W : CNT_W;
    localparam int DATA_W  = 32;
    localparam int LINE_W  = 2 * DATA_W;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);
    localparam logic signed [DATA_W-1:0] MISS_VALUE = -DATA_W'(1);

    typedef enum logic {
        OP_GET = 1'b0,
        OP_PUT = 1'b1
    } op_t;

    typedef struct packed {
        op_t                      operation;
        logic signed [DATA_W-1:0] key;
        logic signed [DATA_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic                     found;
        logic signed [DATA_W-1:0] read_value;
    } rsp_t;

endpackage

// File: sv/lru_kv_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module lru_kv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/lru_key_value_cache_unit.sv
// Fully associative key/value cache with least-recently-used replacement.
//
// Requests arrive on the s_ channel (valid/ready) as a get or a put of a 32-bit
// key and value. Each request yields exactly one response on the m_ channel:
// found, and the stored value on a get hit, -1 on a get miss and 0 for any put.
// cfg_wr_en writes capacity_in_use, the number of entries held before the least
// recent one is evicted; the user must write it only while idle (not enforced).
//
// Keys and values live in a memory that is scanned one entry per cycle
// through its single read port; recency ranks and valid marks are kept
// beside it in registers and are updated for all entries at once.
// A request passes through the accepting idle state, a scan of all entries
// and the update state, after which the response sits in the output register.
// The next request is accepted while that response waits; a stalled receiver
// holds the block in its update state only when the previous response has not
// yet been taken.
//
// Reset clears all valid marks, the entry count and the output valid flag,
// and sets capacity_in_use to 16. The cache is empty after reset.
module lru_key_value_cache_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  lru_kv_pkg::req_t                  s_req,
    output logic                              m_valid,
    input  logic                              m_ready,
    output lru_kv_pkg::rsp_t                  m_rsp,
    input  logic                              cfg_wr_en,
    input  logic [lru_kv_pkg::CAP_W-1:0]      cfg_wr_data
);

    import lru_kv_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_UPDATE = 3'b100
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    req_t                 req_reg, req_next;
    logic [ENTRIES-1:0]   valid_reg, valid_next;
    logic [IDX_W-1:0]     rank_reg [ENTRIES];
    logic [IDX_W-1:0]     rank_next [ENTRIES];
    logic [CNT_W-1:0]     used_reg, used_next;
    logic [CAP_W-1:0]     cap_reg, cap_next;
    logic                 hit_reg, hit_next;
    logic [IDX_W-1:0]     hit_idx_reg, hit_idx_next;
    logic [IDX_W-1:0]     hit_rank_reg, hit_rank_next;
    logic [DATA_W-1:0]    hit_val_reg, hit_val_next;
    logic                 free_found_reg, free_found_next;
    logic [IDX_W-1:0]     free_idx_reg, free_idx_next;
    logic                 m_valid_reg, m_valid_next;
    rsp_t                 m_rsp_reg, m_rsp_next;

    logic                 ram_wr_en;
    logic [IDX_W-1:0]     ram_wr_addr;
    logic [LINE_W-1:0]    ram_wr_data;
    logic                 ram_rd_en;
    logic [LINE_W-1:0]    ram_rd_data;

    logic [EXT_W-1:0]     cap_ext;
    logic [EXT_W-1:0]     eff_cap;
    logic [EXT_W-1:0]     used_ext;
    logic [EXT_W-1:0]     evict_thr;
    logic                 full;
    logic [CNT_W-1:0]     cmp_cnt;
    logic [IDX_W-1:0]     scan_idx;
    logic                 cmp_active;
    logic                 entry_evict;
    logic                 out_free;
    logic [DATA_W-1:0]    rd_key;
    logic [DATA_W-1:0]    rd_val;

    lru_kv_ram #(
        .WIDTH (LINE_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (cnt_reg[IDX_W-1:0]),
        .rd_data (ram_rd_data)
    );

    assign rd_key = ram_rd_data[LINE_W-1:DATA_W];
    assign rd_val = ram_rd_data[DATA_W-1:0];

    assign cap_ext   = EXT_W'(cap_reg);
    assign used_ext  = EXT_W'(used_reg);
    assign eff_cap   = (cap_ext == '0) ? EXT_W'(1) :
                       (cap_ext > EXT_W'(ENTRIES)) ? EXT_W'(ENTRIES) : cap_ext;
    assign evict_thr = eff_cap - EXT_W'(1);
    assign full      = used_ext >= eff_cap;

    assign cmp_cnt     = cnt_reg - CNT_W'(1);
    assign scan_idx    = cmp_cnt[IDX_W-1:0];
    assign cmp_active  = (state_reg == ST_SCAN) && (cnt_reg != '0);
    assign entry_evict = full && (EXT_W'(rank_reg[scan_idx]) >= evict_thr);
    assign out_free    = !m_valid_reg || m_ready;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_rsp   = m_rsp_reg;

    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        req_next        = req_reg;
        valid_next      = valid_reg;
        rank_next       = rank_reg;
        used_next       = used_reg;
        cap_next        = cfg_wr_en ? cfg_wr_data : cap_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        hit_rank_next   = hit_rank_reg;
        hit_val_next    = hit_val_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        m_valid_next    = (m_valid_reg && m_ready) ? 1'b0 : m_valid_reg;
        m_rsp_next      = m_rsp_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = hit_idx_reg;
        ram_wr_data     = {req_reg.key, req_reg.value};
        ram_rd_en       = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    req_next        = s_req;
                    cnt_next        = '0;
                    hit_next        = 1'b0;
                    free_found_next = 1'b0;
                    state_next      = ST_SCAN;
                end
            end
            ST_SCAN: begin
                ram_rd_en = (cnt_reg != CNT_W'(ENTRIES));
                if (cmp_active) begin
                    if (valid_reg[scan_idx] && !hit_reg && (rd_key == req_reg.key)) begin
                        hit_next      = 1'b1;
                        hit_idx_next  = scan_idx;
                        hit_rank_next = rank_reg[scan_idx];
                        hit_val_next  = rd_val;
                    end
                    if (!free_found_reg && !(valid_reg[scan_idx] && !entry_evict)) begin
                        free_found_next = 1'b1;
                        free_idx_next   = scan_idx;
                    end
                end
                if (cnt_reg == CNT_W'(ENTRIES)) begin
                    state_next = ST_UPDATE;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_UPDATE: begin
                if (out_free) begin
                    m_valid_next     = 1'b1;
                    m_rsp_next.found = hit_reg;
                    if (req_reg.operation == OP_GET) begin
                        m_rsp_next.read_value = hit_reg ? hit_val_reg : MISS_VALUE;
                    end else begin
                        m_rsp_next.read_value = '0;
                    end
                    if (hit_reg) begin
                        ram_wr_en   = (req_reg.operation == OP_PUT);
                        ram_wr_addr = hit_idx_reg;
                        for (int i = 0; i < ENTRIES; i++) begin
                            if (valid_reg[i] && (rank_reg[i] < hit_rank_reg)) begin
                                rank_next[i] = rank_reg[i] + IDX_W'(1);
                            end
                            if (IDX_W'(i) == hit_idx_reg) begin
                                rank_next[i] = '0;
                            end
                        end
                    end else if (req_reg.operation == OP_PUT) begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = free_idx_reg;
                        for (int i = 0; i < ENTRIES; i++) begin
                            if (valid_reg[i]) begin
                                if (full && (EXT_W'(rank_reg[i]) >= evict_thr)) begin
                                    valid_next[i] = 1'b0;
                                end else begin
                                    rank_next[i] = rank_reg[i] + IDX_W'(1);
                                end
                            end
                            if (IDX_W'(i) == free_idx_reg) begin
                                valid_next[i] = 1'b1;
                                rank_next[i]  = '0;
                            end
                        end
                        used_next = CNT_W'((full ? evict_thr : used_ext) + EXT_W'(1));
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            valid_reg   <= '0;
            used_reg    <= '0;
            cap_reg     <= CAP_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            valid_reg   <= valid_next;
            used_reg    <= used_next;
            cap_reg     <= cap_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg        <= req_next;
        rank_reg       <= rank_next;
        hit_reg        <= hit_next;
        hit_idx_reg    <= hit_idx_next;
        hit_rank_reg   <= hit_rank_next;
        hit_val_reg    <= hit_val_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        m_rsp_reg      <= m_rsp_next;
    end

endmodule

// File: sv/lru_kv_checker.sv
// Port-level assertions for the LRU key/value cache, bound to the top level.
module lru_kv_checker (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input logic             m_valid,
    input logic             m_ready,
    input lru_kv_pkg::rsp_t m_rsp
);

    import lru_kv_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_rsp))
        else $error("Response changed or dropped while stalled.");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("Request accepted while the previous one is still in work.");

    a_rsp_after_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("Response appeared without a request in work.");

    a_miss_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_rsp.found |-> (m_rsp.read_value == '0) ||
                                    (m_rsp.read_value == MISS_VALUE))
        else $error("Miss response carries a value other than 0 or -1.");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("Response valid after reset.");

endmodule

bind lru_key_value_cache_unit lru_kv_checker u_lru_kv_checker (.*);

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the LRU key/value cache unit with a built-in cache predictor.
module testbench;
    import lru_kv_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;

    logic             aclk;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    req_t             s_req;
    logic             m_valid;
    logic             m_ready;
    rsp_t             m_rsp;
    logic             cfg_wr_en;
    logic [CAP_W-1:0] cfg_wr_data;

    lru_key_value_cache_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_req       (s_req),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_rsp       (m_rsp),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    logic                     line_used [ENTRIES];
    logic signed [DATA_W-1:0] line_key  [ENTRIES];
    logic signed [DATA_W-1:0] line_val  [ENTRIES];
    int unsigned              line_rank [ENTRIES];
    int unsigned              lines_held;
    logic [CAP_W-1:0]         capacity_reg;

    rsp_t                     pending_rsp[$];
    logic signed [DATA_W-1:0] key_pool[$];
    int                       mismatches;
    int                       sink_gap_pct;
    int                       rx_hold_cycles;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("tb: failure");
        $finish;
    end

    function automatic int idle_length();
        if ($urandom_range(9) == 0) begin
            return $urandom_range(40, 10);
        end
        return $urandom_range(3, 1);
    endfunction

    function automatic void make_most_recent(int idx);
        int unsigned r;
        r = line_rank[idx];
        for (int i = 0; i < ENTRIES; i++) begin
            if (line_used[i] && line_rank[i] < r) begin
                line_rank[i]++;
            end
        end
        line_rank[idx] = 0;
    endfunction

    function automatic rsp_t predict_access(req_t r);
        rsp_t        res;
        int          hit_at;
        int          slot;
        int unsigned cap_eff;
        hit_at = -1;
        slot = -1;
        for (int i = 0; i < ENTRIES; i++) begin
            if (hit_at < 0 && line_used[i] && line_key[i] == r.key) begin
                hit_at = i;
            end
        end
        if (r.operation == OP_GET) begin
            if (hit_at >= 0) begin
                make_most_recent(hit_at);
                res.found = 1'b1;
                res.read_value = line_val[hit_at];
            end else begin
                res.found = 1'b0;
                res.read_value = MISS_VALUE;
            end
            return res;
        end
        res.found = (hit_at >= 0);
        res.read_value = '0;
        if (hit_at >= 0) begin
            line_val[hit_at] = r.value;
            make_most_recent(hit_at);
            return res;
        end
        cap_eff = 32'(capacity_reg);
        if (cap_eff < 1) begin
            cap_eff = 1;
        end
        if (cap_eff > ENTRIES) begin
            cap_eff = ENTRIES;
        end
        // A lowered capacity can require several evictions before the insert.
        while (lines_held >= cap_eff) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (line_used[i] && line_rank[i] == lines_held - 1) begin
                    line_used[i] = 1'b0;
                    lines_held--;
                    break;
                end
            end
        end
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!line_used[i]) begin
                slot = i;
            end
        end
        if (slot < 0) begin
            return res;
        end
        for (int i = 0; i < ENTRIES; i++) begin
            if (line_used[i]) begin
                line_rank[i]++;
            end
        end
        line_used[slot] = 1'b1;
        line_key[slot] = r.key;
        line_val[slot] = r.value;
        line_rank[slot] = 0;
        lines_held++;
        return res;
    endfunction

    task automatic send_request(input op_t op, input logic signed [DATA_W-1:0] key,
                                input logic signed [DATA_W-1:0] value, input int gap);
        req_t r;
        r.operation = op;
        r.key = key;
        r.value = value;
        if (gap > 0) begin
            @(negedge aclk);
            s_valid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid = 1'b1;
        s_req = r;
        do @(posedge aclk); while (!s_ready);
        pending_rsp.push_back(predict_access(r));
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_rsp.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_capacity(input logic [CAP_W-1:0] cap);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_wr_data = cap;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        capacity_reg = cap;
    endtask

    task automatic run_random(input int count, input int pool_size, input int src_gap_pct);
        op_t                      op;
        logic signed [DATA_W-1:0] key;
        int                       gap;
        key_pool.delete();
        repeat (pool_size) key_pool.push_back($urandom);
        repeat (count) begin
            op = $urandom_range(1) ? OP_PUT : OP_GET;
            key = ($urandom_range(9) == 0) ? $urandom : key_pool[$urandom_range(pool_size - 1)];
            gap = ($urandom_range(99) < src_gap_pct) ? idle_length() : 0;
            send_request(op, key, $urandom, gap);
        end
    endtask

    task automatic test_basic_access();
        wait_idle();
        send_request(OP_GET, 32'sh0000_0000, 32'sh5A5A_5A5A, 0);
        send_request(OP_PUT, 32'sh8000_0000, 32'sh7FFF_FFFF, 0);
        send_request(OP_PUT, 32'sh7FFF_FFFF, 32'sh8000_0000, 0);
        send_request(OP_PUT, -32'sd1, -32'sd1, 0);
        send_request(OP_PUT, 32'sh0000_0000, 32'sh0000_0000, 0);
        send_request(OP_GET, 32'sh8000_0000, 32'sh0000_0000, 0);
        send_request(OP_GET, 32'sh7FFF_FFFF, -32'sd1, 0);
        send_request(OP_PUT, -32'sd1, 32'sh1234_5678, 0);
        send_request(OP_GET, -32'sd1, 32'sh0000_0000, 0);
        send_request(OP_GET, 32'sh0000_0001, 32'sh0000_0000, 0);
    endtask

    // The cache holds four entries here, so a miss after shrinking must evict three.
    task automatic test_shrink_when_full();
        wait_idle();
        set_capacity(5'd2);
        send_request(OP_PUT, 32'sh0000_0055, 32'shCAFE_0055, 0);
        send_request(OP_GET, -32'sd1, 32'sh0000_0000, 0);
        send_request(OP_GET, 32'sh7FFF_FFFF, 32'sh0000_0000, 0);
        send_request(OP_GET, 32'sh0000_0055, 32'sh0000_0000, 0);
    endtask

    task automatic test_capacity_floor();
        wait_idle();
        set_capacity(5'd0);
        send_request(OP_PUT, 32'sh0000_000A, 32'sh0000_00A0, 0);
        send_request(OP_PUT, 32'sh0000_000B, 32'sh0000_00B0, 0);
        send_request(OP_GET, 32'sh0000_000A, 32'sh0000_0000, 0);
        send_request(OP_GET, 32'sh0000_000B, 32'sh0000_0000, 0);
    endtask

    task automatic test_random_capacities();
        logic [CAP_W-1:0] caps [9];
        int               cap_eff;
        caps = '{5'd16, 5'd1, 5'd31, 5'd2, 5'd5, 5'd0, 5'd17, 5'd8, 5'd0};
        caps[8] = CAP_W'($urandom);
        foreach (caps[n]) begin
            wait_idle();
            sink_gap_pct = $urandom_range(50, 10);
            cap_eff = int'(caps[n]);
            if (cap_eff < 1) begin
                cap_eff = 1;
            end
            if (cap_eff > ENTRIES) begin
                cap_eff = ENTRIES;
            end
            set_capacity(caps[n]);
            run_random(120, cap_eff + 1 + $urandom_range(cap_eff), 30);
        end
    endtask

    task automatic test_output_backpressure();
        wait_idle();
        rx_hold_cycles = 400;
        run_random(60, 12, 0);
    endtask

    task automatic test_steady_stream();
        wait_idle();
        sink_gap_pct = 0;
        set_capacity(5'd12);
        run_random(120, 16, 0);
        sink_gap_pct = 30;
    endtask

    initial begin : sink
        int gap_left;
        gap_left = 0;
        forever begin
            @(negedge aclk);
            if (rx_hold_cycles > 0) begin
                m_ready = 1'b0;
                rx_hold_cycles--;
            end else if (gap_left > 0) begin
                m_ready = 1'b0;
                gap_left--;
            end else begin
                m_ready = 1'b1;
                if ($urandom_range(99) < sink_gap_pct) begin
                    gap_left = idle_length();
                end
            end
        end
    end

    always @(posedge aclk) begin : check_rsp
        rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_rsp.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected response: found=%0b read_value=%h",
                             m_rsp.found, m_rsp.read_value);
                end
            end else begin
                want = pending_rsp.pop_front();
                if (m_rsp.found !== want.found || m_rsp.read_value !== want.read_value) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display({"mismatch: expected found=%0b read_value=%h, ",
                                  "got found=%0b read_value=%h"},
                                 want.found, want.read_value, m_rsp.found, m_rsp.read_value);
                    end
                end
            end
        end
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_req = '0;
        m_ready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        mismatches = 0;
        sink_gap_pct = 30;
        rx_hold_cycles = 0;
        lines_held = 0;
        capacity_reg = CAP_RESET;
        for (int i = 0; i < ENTRIES; i++) begin
            line_used[i] = 1'b0;
            line_rank[i] = 0;
        end
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_basic_access();
        test_shrink_when_full();
        test_capacity_floor();
        test_random_capacities();
        test_output_backpressure();
        test_steady_stream();

        wait_idle();
        repeat (40) @(posedge aclk);
        if (mismatches == 0 && pending_rsp.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
